/* hdl/dpb_pkg.sv */
// Shared constants, register codes and saturation helpers for depth back-projection.
package dpb_pkg;

	localparam int DEPTH_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int POS_W      = 12;
	localparam int POINT_W    = 37;
	localparam int RCOL_W     = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int SCALE_W    = 16;
	localparam int FOCAL_W    = 20;
	localparam int CENTER_W   = 16;
	localparam int BASE_W     = 24;
	localparam int NUM_W      = 62;
	localparam int DEN_W      = 38;
	localparam int DEF_COORD_WIDTH = 12;

	localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = SCALE_W'(1000);
	localparam logic [FOCAL_W-1:0]  RST_FOCAL_X     = FOCAL_W'(8400);
	localparam logic [FOCAL_W-1:0]  RST_FOCAL_Y     = FOCAL_W'(8400);
	localparam logic [CENTER_W-1:0] RST_CENTER_X    = CENTER_W'(5120);
	localparam logic [CENTER_W-1:0] RST_CENTER_Y    = CENTER_W'(3840);
	localparam logic signed [BASE_W-1:0] RST_BASELINE = -BASE_W'(7866);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_SCALE = 3'd0,
		REG_FOCAL_X     = 3'd1,
		REG_FOCAL_Y     = 3'd2,
		REG_CENTER_X    = 3'd3,
		REG_CENTER_Y    = 3'd4,
		REG_BASELINE    = 3'd5
	} cfg_reg_t;

	function automatic logic signed [POINT_W-1:0] sat_point(input logic signed [NUM_W:0] v);
		logic signed [NUM_W:0] hi;
		logic signed [NUM_W:0] lo;
		hi = {{(NUM_W+2-POINT_W){1'b0}}, {(POINT_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			sat_point = hi[POINT_W-1:0];
		end else if (v < lo) begin
			sat_point = lo[POINT_W-1:0];
		end else begin
			sat_point = v[POINT_W-1:0];
		end
	endfunction

	function automatic logic signed [RCOL_W-1:0] sat_rcol(input logic signed [NUM_W:0] v);
		logic signed [NUM_W:0] hi;
		logic signed [NUM_W:0] lo;
		hi = {{(NUM_W+2-RCOL_W){1'b0}}, {(RCOL_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			sat_rcol = hi[RCOL_W-1:0];
		end else if (v < lo) begin
			sat_rcol = lo[RCOL_W-1:0];
		end else begin
			sat_rcol = v[RCOL_W-1:0];
		end
	endfunction

endpackage

/* hdl/depth_pixel_backprojection.sv */
// Top level: pinhole depth-pixel back-projection to a coloured point cloud.
//
// Takes one depth pixel per cycle on the slave stream while the output is not
// stalled and returns one point per non-zero depth on the master stream; a pixel
// with zero depth is dropped as a bubble.
// The point is computed by four 62-stage restoring dividers (x, y, z and the
// right-view disparity) that run side by side; the three stages in front form the
// products and the rounded numerators. The whole pipeline stalls as one while a
// finished point waits in the output register (s_tready = !m_tvalid | m_tready).
// Registers are written through the cfg channel, which is always ready; write
// them only with the pipeline empty. A zero scale or focal length acts as one.
module depth_pixel_backprojection #(
	parameter int COORD_WIDTH = dpb_pkg::DEF_COORD_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	// fields from bit 0: depth_raw, pixel_col, pixel_row, in_red, in_green, in_blue
	input  logic [((40 + 2*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	// fields from bit 0: point_x, point_y, point_z, out_red, out_green, out_blue,
	// left_col, left_row, rview_col
	output logic [183:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpb_pkg::*;

	localparam int C16_W = COORD_WIDTH + 4;
	localparam int DX_W  = ((C16_W > CENTER_W) ? C16_W : CENTER_W) + 1;
	localparam int DXD_W = DX_W + DEPTH_W + 1;
	localparam int FS_W  = FOCAL_W + SCALE_W;
	localparam int BF_W  = BASE_W + FOCAL_W + 1;
	localparam int BFS_W = BF_W + SCALE_W + 1;

	typedef struct packed {
		logic                   valid;
		logic [COORD_WIDTH-1:0] col;
		logic [COORD_WIDTH-1:0] row;
		logic [COLOR_W-1:0]     red;
		logic [COLOR_W-1:0]     green;
		logic [COLOR_W-1:0]     blue;
	} pix_t;

	typedef struct packed {
		pix_t pix;
		logic neg_x;
		logic neg_y;
		logic neg_r;
	} side_t;

	// ---------------- configuration registers ----------------
	logic [SCALE_W-1:0]        depth_scale_q;
	logic [FOCAL_W-1:0]        focal_x_q;
	logic [FOCAL_W-1:0]        focal_y_q;
	logic [CENTER_W-1:0]       center_x_q;
	logic [CENTER_W-1:0]       center_y_q;
	logic signed [BASE_W-1:0]  baseline_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_scale_q <= RST_DEPTH_SCALE;
			focal_x_q     <= RST_FOCAL_X;
			focal_y_q     <= RST_FOCAL_Y;
			center_x_q    <= RST_CENTER_X;
			center_y_q    <= RST_CENTER_Y;
			baseline_q    <= RST_BASELINE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEPTH_SCALE: depth_scale_q <= cfg_data[SCALE_W-1:0];
				REG_FOCAL_X:     focal_x_q     <= cfg_data[FOCAL_W-1:0];
				REG_FOCAL_Y:     focal_y_q     <= cfg_data[FOCAL_W-1:0];
				REG_CENTER_X:    center_x_q    <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[CENTER_W-1:0];
				REG_BASELINE:    baseline_q    <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// zero register values act as one
	logic [SCALE_W-1:0] scale_nz;
	logic [FOCAL_W-1:0] fx_nz;
	logic [FOCAL_W-1:0] fy_nz;
	assign scale_nz = (depth_scale_q == '0) ? SCALE_W'(1) : depth_scale_q;
	assign fx_nz    = (focal_x_q == '0) ? FOCAL_W'(1) : focal_x_q;
	assign fy_nz    = (focal_y_q == '0) ? FOCAL_W'(1) : focal_y_q;

	// ---------------- input unpack ----------------
	logic [DEPTH_W-1:0]     in_depth;
	pix_t                   in_pix;
	assign in_depth     = s_tdata[DEPTH_W-1:0];
	assign in_pix.col   = s_tdata[DEPTH_W +: COORD_WIDTH];
	assign in_pix.row   = s_tdata[DEPTH_W+COORD_WIDTH +: COORD_WIDTH];
	assign in_pix.red   = s_tdata[DEPTH_W+2*COORD_WIDTH +: COLOR_W];
	assign in_pix.green = s_tdata[DEPTH_W+2*COORD_WIDTH+COLOR_W +: COLOR_W];
	assign in_pix.blue  = s_tdata[DEPTH_W+2*COORD_WIDTH+2*COLOR_W +: COLOR_W];
	assign in_pix.valid = s_tvalid && (in_depth != '0);

	// one stall signal for the whole pipe
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---------------- stage 1: offsets and first products ----------------
	pix_t                     pix_s1;
	logic [DEPTH_W-1:0]       d_s1;
	logic signed [DX_W-1:0]   dx_s1, dy_s1;
	logic [FS_W-1:0]          fxs_s1, fys_s1;
	logic signed [BF_W-1:0]   bf_s1;
	logic [SCALE_W-1:0]       s_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else if (adv) begin
			pix_s1 <= in_pix;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1   <= in_depth;
			dx_s1  <= $signed(DX_W'({in_pix.col, 4'b0})) - $signed(DX_W'(center_x_q));
			dy_s1  <= $signed(DX_W'({in_pix.row, 4'b0})) - $signed(DX_W'(center_y_q));
			fxs_s1 <= fx_nz * scale_nz;
			fys_s1 <= fy_nz * scale_nz;
			bf_s1  <= BF_W'(baseline_q) * $signed({1'b0, fx_nz});
			s_s1   <= scale_nz;
		end
	end

	// ---------------- stage 2: depth products ----------------
	pix_t                     pix_s2;
	logic [DEPTH_W-1:0]       d_s2;
	logic signed [DXD_W-1:0]  dxd_s2, dyd_s2;
	logic [FS_W-1:0]          fxs_s2, fys_s2;
	logic signed [BFS_W-1:0]  bfs_s2;
	logic [SCALE_W-1:0]       s_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s2 <= '0;
		end else if (adv) begin
			pix_s2 <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2   <= d_s1;
			dxd_s2 <= DXD_W'(dx_s1) * $signed({1'b0, d_s1});
			dyd_s2 <= DXD_W'(dy_s1) * $signed({1'b0, d_s1});
			fxs_s2 <= fxs_s1;
			fys_s2 <= fys_s1;
			bfs_s2 <= BFS_W'(bf_s1) * $signed({1'b0, s_s1});
			s_s2   <= s_s1;
		end
	end

	// ---------------- stage 3: rounded numerators, divisors ----------------
	// round to nearest, ties away: q = (2|n| + den) / (2 den)
	logic [DXD_W-1:0] mag_x, mag_y;
	logic [BFS_W-1:0] mag_r;
	assign mag_x = dxd_s2[DXD_W-1] ? DXD_W'(-dxd_s2) : DXD_W'(dxd_s2);
	assign mag_y = dyd_s2[DXD_W-1] ? DXD_W'(-dyd_s2) : DXD_W'(dyd_s2);
	assign mag_r = bfs_s2[BFS_W-1] ? BFS_W'(-bfs_s2) : BFS_W'(bfs_s2);

	side_t            side_s3;
	logic [NUM_W-1:0] xnum_s3, ynum_s3, znum_s3, rnum_s3;
	logic [DEN_W-1:0] xden_s3, yden_s3, zden_s3, rden_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (adv) begin
			side_s3.pix   <= pix_s2;
			side_s3.neg_x <= dxd_s2[DXD_W-1];
			side_s3.neg_y <= dyd_s2[DXD_W-1];
			side_s3.neg_r <= bfs_s2[BFS_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xnum_s3 <= (NUM_W'(mag_x) << 17) + NUM_W'(fxs_s2);
			xden_s3 <= DEN_W'(fxs_s2) << 1;
			ynum_s3 <= (NUM_W'(mag_y) << 17) + NUM_W'(fys_s2);
			yden_s3 <= DEN_W'(fys_s2) << 1;
			znum_s3 <= (NUM_W'(d_s2) << 17) + NUM_W'(s_s2);
			zden_s3 <= DEN_W'(s_s2) << 1;
			rnum_s3 <= (NUM_W'(mag_r) << 1) + (NUM_W'(d_s2) << 16);
			rden_s3 <= DEN_W'(d_s2) << 17;
		end
	end

	// ---------------- dividers, sideband delay line alongside ----------------
	logic [NUM_W-1:0] qx, qy, qz, qr;

	dpb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
		.clk(clk), .en(adv), .num(xnum_s3), .den(xden_s3), .quo(qx));
	dpb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
		.clk(clk), .en(adv), .num(ynum_s3), .den(yden_s3), .quo(qy));
	dpb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_z (
		.clk(clk), .en(adv), .num(znum_s3), .den(zden_s3), .quo(qz));
	dpb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_r (
		.clk(clk), .en(adv), .num(rnum_s3), .den(rden_s3), .quo(qr));

	side_t side_q [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_side
		side_t side_in;
		if (k == 0) begin : g_first
			assign side_in = side_s3;
		end else begin : g_next
			assign side_in = side_q[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_q[k] <= '0;
			end else if (adv) begin
				side_q[k] <= side_in;
			end
		end
	end

	// ---------------- output stage: signs, saturation ----------------
	side_t                 side_last;
	logic signed [NUM_W:0] vx, vy, vz, vr;
	assign side_last = side_q[NUM_W-1];
	assign vx = side_last.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	// y and z leave negated (turn about the x axis)
	assign vy = side_last.neg_y ? $signed({1'b0, qy}) : -$signed({1'b0, qy});
	assign vz = -$signed({1'b0, qz});
	assign vr = $signed((NUM_W+1)'({side_last.pix.col, 4'b0}))
		+ (side_last.neg_r ? -$signed({1'b0, qr}) : $signed({1'b0, qr}));

	logic signed [POINT_W-1:0] px_q, py_q, pz_q;
	logic signed [RCOL_W-1:0]  rc_q;
	pix_t                      pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= side_last.pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_q <= side_last.pix;
			px_q  <= sat_point(vx);
			py_q  <= sat_point(vy);
			pz_q  <= sat_point(vz);
			rc_q  <= sat_rcol(vr);
		end
	end

	assign m_tdata = {5'b0, rc_q, POS_W'(pix_q.row), POS_W'(pix_q.col),
		pix_q.blue, pix_q.green, pix_q.red, pz_q, py_q, px_q};

	// ---------------- assertions ----------------
	a_zero_depth_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (in_depth == '0) |=> !pix_s1.valid)
		else $error("zero-depth pixel entered the pipeline");

	a_depth_negative: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[110])
		else $error("point_z not negative on a valid point");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(side_s3.pix.valid) && $stable(side_last.pix.valid))
		else $error("pipeline moved during a stall");

endmodule

/* hdl/dpb_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module dpb_div #(
	parameter int NUM_W = dpb_pkg::NUM_W,
	parameter int DEN_W = dpb_pkg::DEN_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	// payload only, no reset
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nrest_s [NUM_W];
	logic [NUM_W-1:0] q_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] nrest_in;
		logic [NUM_W-1:0] q_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in   = '0;
			assign nrest_in = num;
			assign q_in     = '0;
			assign den_in   = den;
		end else begin : g_next
			assign rem_in   = rem_s[k-1];
			assign nrest_in = nrest_s[k-1];
			assign q_in     = q_s[k-1];
			assign den_in   = den_s[k-1];
		end

		assign trial = {rem_in, nrest_in[NUM_W-1]};
		assign ge    = (trial >= {1'b0, den_in});
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				nrest_s[k] <= {nrest_in[NUM_W-2:0], 1'b0};
				q_s[k]     <= {q_in[NUM_W-2:0], ge};
				den_s[k]   <= den_in;
			end
		end
	end

	assign quo = q_s[NUM_W-1];

endmodule
